// ===== sv/tdd_pkg.sv =====
// ============================================================================
// tdd_pkg: shared types for the trial division divisor lister
// Holds the controller state encoding and the status bundle that the serial
// remainder unit reports back to the controller.
// ============================================================================
package tdd_pkg;

    // Controller states of one run.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT,
        ST_FINISH
    } state_t;

    // Status returned by the serial remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } rem_status_t;

endpackage

// ===== sv/tdd_serial_rem.sv =====
// ============================================================================
// tdd_serial_rem: bit-serial remainder unit
// Restoring division that shifts in one dividend bit per cycle and reports
// whether the remainder is zero.
// ============================================================================
module tdd_serial_rem #(
    parameter int NUM_WIDTH = 16,
    parameter int CAND_WIDTH = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUM_WIDTH-1:0]    dividend,
    input  logic [CAND_WIDTH-1:0]   divisor,
    output tdd_pkg::rem_status_t    status
);

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [NUM_WIDTH-1:0]  shift_reg, shift_next;
    logic [CAND_WIDTH-1:0] rem_reg, rem_next;
    logic [CAND_WIDTH-1:0] dsr_reg, dsr_next;
    logic [CAND_WIDTH:0]   trial;
    logic [CAND_WIDTH:0]   diff;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    assign trial = {rem_reg, shift_reg[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(NUM_WIDTH);
            shift_next = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[NUM_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[CAND_WIDTH-1:0];
            end
            else
            begin
                rem_next = trial[CAND_WIDTH-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers reset; the datapath needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

// ===== sv/trial_division_divisor_lister.sv =====
// ============================================================================
// trial_division_divisor_lister: lists the divisors of a number up to its root
// The factor 1 is held until the next divisor is found or the run ends.
// Each candidate is tested in the bit-serial remainder unit; a divisor then waits
// in the emit state until the output slot is free, so output stalls lengthen a run.
// One number is in work at a time; the next transfer waits for the idle state.
// Reset (asynchronous, active low) returns the block to idle with no result held.
// ============================================================================
module trial_division_divisor_lister #(
    parameter int NUM_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [NUM_WIDTH-1:0] number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           factor,
    output logic                 last
);

    localparam int CAND_WIDTH = (NUM_WIDTH + 1) / 2 + 1;
    localparam int SQ_WIDTH   = 2 * CAND_WIDTH;

    tdd_pkg::state_t       state_reg, state_next;
    tdd_pkg::rem_status_t  rem_status;

    logic [NUM_WIDTH-1:0]  num_reg, num_next;
    logic [CAND_WIDTH-1:0] cand_reg, cand_next;
    logic [SQ_WIDTH-1:0]   sq_reg, sq_next;
    logic [7:0]            pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            factor_reg, factor_next;
    logic                  last_reg, last_next;

    logic                  in_xfer;
    logic                  slot_free;
    logic                  in_range;
    logic                  div_start;

    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_range  = (sq_reg <= {{(SQ_WIDTH-NUM_WIDTH){1'b0}}, num_reg});
    assign div_start = (state_reg == tdd_pkg::ST_CHECK) && in_range;

    // Serial remainder of the held number by the current candidate.
    tdd_serial_rem #(
        .NUM_WIDTH  (NUM_WIDTH),
        .CAND_WIDTH (CAND_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (cand_reg),
        .status   (rem_status)
    );

    // Next state of the run controller.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdd_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = tdd_pkg::ST_CHECK;
                end
            end
            tdd_pkg::ST_CHECK:
            begin
                state_next = in_range ? tdd_pkg::ST_DIVIDE : tdd_pkg::ST_FINISH;
            end
            tdd_pkg::ST_DIVIDE:
            begin
                if (rem_status.done)
                begin
                    state_next = rem_status.zero ? tdd_pkg::ST_EMIT : tdd_pkg::ST_CHECK;
                end
            end
            tdd_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = tdd_pkg::ST_CHECK;
                end
            end
            tdd_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = tdd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates for each state.
    always_comb
    begin
        in_ready       = (state_reg == tdd_pkg::ST_IDLE);
        num_next       = num_reg;
        cand_next      = cand_reg;
        sq_next        = sq_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        factor_next    = factor_reg;
        last_next      = last_reg;
        unique case (state_reg)
            tdd_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    num_next  = number;
                    cand_next = CAND_WIDTH'(2);
                    sq_next   = SQ_WIDTH'(4);
                    pend_next = 8'd1;
                end
            end
            tdd_pkg::ST_DIVIDE:
            begin
                // A candidate that leaves a remainder is skipped at once.
                if (rem_status.done && !rem_status.zero)
                begin
                    cand_next = cand_reg + CAND_WIDTH'(1);
                    sq_next   = sq_reg + SQ_WIDTH'({cand_reg, 1'b1});
                end
            end
            tdd_pkg::ST_EMIT:
            begin
                // The held factor is not the last one; the new divisor takes its place.
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    factor_next    = pend_reg;
                    last_next      = 1'b0;
                    pend_next      = 8'(cand_reg);
                    cand_next      = cand_reg + CAND_WIDTH'(1);
                    sq_next        = sq_reg + SQ_WIDTH'({cand_reg, 1'b1});
                end
            end
            tdd_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    factor_next    = pend_reg;
                    last_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state resets; payload registers do not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        cand_reg   <= cand_next;
        sq_reg     <= sq_next;
        pend_reg   <= pend_next;
        factor_reg <= factor_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign factor    = factor_reg;
    assign last      = last_reg;

    // The running square always matches the candidate during a run.
    a_square_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tdd_pkg::ST_IDLE) |->
            (sq_reg == (SQ_WIDTH'(cand_reg) * SQ_WIDTH'(cand_reg))))
        else $error("running square out of step with candidate");

    // A remainder is only started while the unit is free.
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !rem_status.busy)
        else $error("remainder unit restarted while busy");

    // A remainder completes only while the controller waits for it.
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        rem_status.done |-> (state_reg == tdd_pkg::ST_DIVIDE))
        else $error("remainder finished outside the divide state");

    // No result ever carries a zero factor.
    a_factor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (factor_reg != 8'd0))
        else $error("zero factor presented");

endmodule
